/* hw/rtl/stq_pkg.sv */
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;
  localparam int unsigned SLOT_COUNT_DEF    = 16;
  localparam int unsigned CHANNEL_COUNT_DEF = 16;
  localparam int unsigned MAX_BURST         = 16;
  localparam logic [31:0] ALL_ONES          = 32'hffffffff;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_ALLOC = 3'd1,
    ACT_FREE  = 3'd2,
    ACT_BIND  = 3'd3,
    ACT_ARM   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_ALLOC  = 2'd1,
    KIND_NOFREE = 2'd2,
    KIND_EXPIRY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_PEND  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_EXPIRE,
    S_OUT
  } fsm_t;

  // One slot as it travels through the sorted row: the row holds pending
  // slots in deadline order, position 0 is the head.
  typedef struct packed {
    logic        vld;
    logic [5:0]  slot;
    logic [31:0] deadline;
  } entry_t;

  // Row command broadcast to every cell.
  typedef struct packed {
    logic        ins;     // insert key, shifting the tail down
    logic        del;     // remove key slot, shifting the tail up
    logic        pop;     // remove head, shifting up
    logic [5:0]  slot;
    logic [31:0] deadline;
  } row_cmd_t;
endpackage

/* hw/rtl/stq_cell.sv */
// ----------------------------------------------------------------------------
// stq_cell
// One position of the sorted pending row.
// ----------------------------------------------------------------------------
module stq_cell import stq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  row_cmd_t cmd,
  input  entry_t   prev_i,   // neighbor toward head
  input  entry_t   next_i,   // neighbor toward tail
  input  logic     prev_goes_i, // insertion point above this cell
  input  logic     prev_del_i,  // deleted slot above this cell
  output logic     goes_o,
  output logic     del_o,
  output entry_t   ent_o
);
  entry_t ent_r, ent_nxt;
  logic   here_ins, here_del;

  // Insert before first entry with deadline >= key; empty cells count as greater.
  assign here_ins = !ent_r.vld || (cmd.deadline <= ent_r.deadline);
  assign goes_o   = prev_goes_i || here_ins;
  assign here_del = ent_r.vld && (ent_r.slot == cmd.slot);
  assign del_o    = prev_del_i || here_del;
  assign ent_o    = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    priority if (cmd.pop) begin
      ent_nxt = next_i;
    end else if (cmd.del) begin
      if (del_o) ent_nxt = next_i;
    end else if (cmd.ins) begin
      if (prev_goes_i) ent_nxt = prev_i;
      else if (here_ins) begin
        ent_nxt.vld      = 1'b1;
        ent_nxt.slot     = cmd.slot;
        ent_nxt.deadline = cmd.deadline;
      end
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ent_r.vld <= 1'b0;
    else        ent_r     <= ent_nxt;
  end
endmodule

/* hw/rtl/stq_row.sv */
// ----------------------------------------------------------------------------
// stq_row
// Chain of cells holding pending slots sorted by deadline.
// ----------------------------------------------------------------------------
module stq_row import stq_pkg::*; #(
  parameter int unsigned DEPTH = SLOT_COUNT_DEF - 1
) (
  input  logic     clk,
  input  logic     rst_n,
  input  row_cmd_t cmd,
  output entry_t   head_o
);
  entry_t ent   [DEPTH+1];
  logic   goes  [DEPTH+1];
  logic   dels  [DEPTH+1];

  assign goes[0] = 1'b0;
  assign dels[0] = 1'b0;
  assign ent[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prv;
    assign prv = (i == 0) ? entry_t'('0) : ent[(i == 0) ? 0 : i-1];
    stq_cell u_cell (
      .clk, .rst_n, .cmd,
      .prev_i(prv), .next_i(ent[i+1]),
      .prev_goes_i(goes[i]), .prev_del_i(dels[i]),
      .goes_o(goes[i+1]), .del_o(dels[i+1]), .ent_o(ent[i])
    );
  end

  assign head_o = ent[0];
endmodule

/* hw/rtl/sorted_timer_queue_core.sv */
// ----------------------------------------------------------------------------
// sorted_timer_queue_core
// Timer slot pool with a deadline-sorted pending row of cells.
// ----------------------------------------------------------------------------
// Usage: items enter on in_* (valid/stall), results leave on out_* with
// out_last marking the final result of an item. Every item yields at least
// one result. All cells of the row shift together; arm of a pending slot
// first removes it from the row and then reinserts it with the new
// deadline. alloc scans slot status one slot a cycle while the result
// register is free, from slot 0 up to the last slot. A tick that expires
// slots gives one result per cycle while the receiver does not stall, at
// most 16, each popping the row head. The block holds one item at a time;
// in_stall is high while an item is in work. When the receiver stalls, the
// result register holds and the sequence waits. Reset empties the row
// (empty cells count as later than any deadline), marks slot 0 pending,
// frees all other slots and clears the tick count.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core import stq_pkg::*; #(
  parameter int unsigned SLOT_COUNT    = SLOT_COUNT_DEF,
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [3:0]         in_slot_index,
  input  logic [31:0]        in_delay,
  input  logic [3:0]         in_channel,
  input  logic signed [31:0] in_payload,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [3:0]         out_result_slot,
  output logic [3:0]         out_result_channel,
  output logic signed [31:0] out_result_payload,
  output logic               out_last
);
  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned BW = $clog2(MAX_BURST + 1);

  fsm_t state_r, state_nxt;
  logic [31:0] tick_r, tick_nxt;
  status_t status_r [SLOT_COUNT];
  logic [CW-1:0] chan_r [SLOT_COUNT];
  logic [31:0]   pay_r  [SLOT_COUNT];
  logic [SW-1:0] scan_r;
  logic [BW-1:0] burst_r;
  logic          rearm_r;
  logic [5:0]    aslot_r;
  logic [31:0]   adl_r;

  logic [1:0]  okind_r;
  logic [3:0]  oslot_r, ochan_r;
  logic [31:0] opay_r;
  logic        olast_r, ovalid_r;

  row_cmd_t cmd;
  entry_t   head;

  stq_row #(.DEPTH(SLOT_COUNT - 1)) u_row (.clk, .rst_n, .cmd, .head_o(head));

  logic acc, emit, sidx_ok;
  logic [SW-1:0] sidx;
  logic [31:0] tick_inc;
  logic head_due;
  logic [SW-1:0] hslot;
  logic oready, alloc_hit, pop_go, oload;

  assign acc      = in_valid && !in_stall;
  assign emit     = ovalid_r && !out_stall;
  assign sidx     = SW'(in_slot_index);
  assign sidx_ok  = (in_slot_index != 4'd0) && (32'(in_slot_index) < SLOT_COUNT);
  assign tick_inc = tick_r + 32'd1;
  assign hslot    = SW'(head.slot);
  assign head_due = head.vld && (head.deadline <= tick_r);
  assign in_stall = (state_r != S_IDLE);

  // result register free for a new item in this cycle
  assign oready    = !ovalid_r || emit;
  assign alloc_hit = (status_r[scan_r] == ST_FREE) || (32'(scan_r) == SLOT_COUNT - 1);
  assign pop_go    = oready && head_due && (burst_r != BW'(MAX_BURST));
  assign oload     = (state_r == S_ALLOC && oready && alloc_hit) ||
                     (state_r == S_EXPIRE && pop_go) ||
                     (state_r == S_OUT && !rearm_r && oready && burst_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc) begin
        if (in_action == ACT_ALLOC) state_nxt = S_ALLOC;
        else if (in_action == ACT_TICK) state_nxt = S_EXPIRE;
        else state_nxt = S_OUT;
      end
      S_ALLOC:  if (oready && alloc_hit) state_nxt = S_OUT;
      S_EXPIRE: if (oready) begin
        if (!head_due || burst_r == BW'(MAX_BURST)) state_nxt = S_OUT;
      end
      S_OUT: if (rearm_r) state_nxt = S_OUT;
             else if (oready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.slot = aslot_r;
    cmd.deadline = adl_r;
    if (state_r == S_IDLE && acc && sidx_ok &&
        (in_action == ACT_FREE || in_action == ACT_ARM) &&
        status_r[sidx] == ST_PEND) begin
      cmd.del  = 1'b1;
      cmd.slot = 6'(in_slot_index);
    end else if (state_r == S_IDLE && acc && sidx_ok && in_action == ACT_ARM &&
                 status_r[sidx] == ST_ALLOC) begin
      cmd.ins = 1'b1;
      cmd.slot = 6'(in_slot_index);
      cmd.deadline = tick_r + in_delay;
    end else if (state_r == S_OUT && rearm_r) begin
      cmd.ins = 1'b1;
    end else if (state_r == S_EXPIRE && pop_go) begin
      cmd.pop = 1'b1;
    end
  end

  assign tick_nxt = (state_r == S_IDLE && acc && in_action == ACT_TICK) ? tick_inc : tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tick_r   <= '0;
      ovalid_r <= 1'b0;
      rearm_r  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) status_r[i] <= (i == 0) ? ST_PEND : ST_FREE;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      if (oload)     ovalid_r <= 1'b1;
      else if (emit) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (acc) begin
          scan_r  <= '0;
          burst_r <= '0;
          aslot_r <= 6'(in_slot_index);
          adl_r   <= tick_r + in_delay;
          rearm_r <= sidx_ok && (in_action == ACT_ARM) && (status_r[sidx] == ST_PEND);
          if (sidx_ok) begin
            unique case (in_action)
              ACT_FREE: status_r[sidx] <= ST_FREE;
              ACT_BIND: begin
                chan_r[sidx] <= (32'(in_channel) < CHANNEL_COUNT) ?
                                CW'(in_channel) : CW'(CHANNEL_COUNT - 1);
                pay_r[sidx]  <= in_payload;
              end
              ACT_ARM: if (status_r[sidx] != ST_FREE) status_r[sidx] <= ST_PEND;
              default: ;
            endcase
          end
        end
        S_ALLOC: if (oready) begin
          if (status_r[scan_r] == ST_FREE) begin
            status_r[scan_r] <= ST_ALLOC;
            okind_r <= KIND_ALLOC;
            oslot_r <= 4'(scan_r);
            ochan_r <= '0; opay_r <= '0; olast_r <= 1'b1;
            burst_r <= BW'(1);
          end else if (32'(scan_r) == SLOT_COUNT - 1) begin
            okind_r <= KIND_NOFREE;
            oslot_r <= '0; ochan_r <= '0; opay_r <= '0; olast_r <= 1'b1;
            burst_r <= BW'(1);
          end
          scan_r <= scan_r + SW'(1);
        end
        S_EXPIRE: if (pop_go) begin
          status_r[hslot] <= ST_ALLOC;
          okind_r  <= KIND_EXPIRY;
          oslot_r  <= 4'(head.slot);
          ochan_r  <= 4'(chan_r[hslot]);
          opay_r   <= pay_r[hslot];
          // last is known only once the next head is seen; fix up below
          olast_r  <= 1'b0;
          burst_r  <= burst_r + BW'(1);
        end
        S_OUT: begin
          if (rearm_r) rearm_r <= 1'b0;
          else if (oready && burst_r == '0) begin
            okind_r <= KIND_DONE;
            oslot_r <= '0; ochan_r <= '0; opay_r <= '0; olast_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // During a burst the held expiry is final when no further pop will follow.
  logic last_now;
  assign last_now = (okind_r != KIND_EXPIRY) || olast_r ||
                    (state_r == S_OUT) ||
                    (state_r == S_EXPIRE && (!head_due || burst_r == BW'(MAX_BURST)));

  assign out_valid          = ovalid_r;
  assign out_kind           = okind_r;
  assign out_result_slot    = oslot_r;
  assign out_result_channel = ochan_r;
  assign out_result_payload = opay_r;
  assign out_last           = last_now;
endmodule
